/* design/mep_pkg.sv */
package mep_pkg;

    // Fixed-point format of every coordinate: signed Q8.24.
    localparam int unsigned FRAC_BITS = 24;

    // Width of the guarded sums that are saturated back to 32 bits.
    localparam int unsigned SAT_W = 48;

    // Escape threshold on the exact sum of squares: 4.0 in Q16.48.
    localparam logic [63:0] ESC_LIMIT = 64'h0004_0000_0000_0000;

    localparam logic [7:0] GREEN_STEP = 8'd10;
    localparam logic [7:0] FULL_BYTE  = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_LEFT_X   = 3'd0,
        REG_TOP_Y    = 3'd1,
        REG_STEP_X   = 3'd2,
        REG_STEP_Y   = 3'd3,
        REG_MAX_ITER = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] left_x;
        logic signed [31:0] top_y;
        logic signed [31:0] step_x;
        logic signed [31:0] step_y;
        logic        [7:0]  max_iterations;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pix;  // capture the clamped pixel position
        logic calc_c;    // form column*step_x and row*step_y
        logic load_c;    // latch c and start z at c
        logic mul;       // form the three products of z
        logic step;      // write back the next z
        logic first;     // the pending step is the one that forms z_0
        logic load_out;  // write the result into the output register
        logic out_axis;  // the result is the black on-axis pixel
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic on_axis;   // c has a zero coordinate
        logic escape;    // |z|^2 > 4 for the current z
        logic at_limit;  // iteration index has reached max_iterations
    } status_t;

    // Clamp a guarded signed sum to the 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-32:0] upper;
        logic signed [31:0] res;
        upper = v[SAT_W-1:31];
        if ((&upper) || (~|upper)) begin
            res = v[31:0];
        end else if (v[SAT_W-1]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

endpackage

/* design/mep_ctrl.sv */
module mep_ctrl
    import mep_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMUL,
        S_CADD,
        S_MUL,
        S_STEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   first_reg;
    logic   first_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new word when empty or being emptied.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.first  = first_reg;
        state_next = state_reg;
        first_next = first_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = S_CMUL;
                end
            end
            S_CMUL:
            begin
                cmd.calc_c = 1'b1;
                state_next = S_CADD;
            end
            S_CADD:
            begin
                if (status.on_axis)
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.out_axis = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.load_c = 1'b1;
                    first_next = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (!first_reg && (status.escape || status.at_limit))
                begin
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    first_next = 1'b0;
                    state_next = S_MUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* design/mep_datapath.sv */
module mep_datapath
    import mep_pkg::*;
#(
    parameter int COLUMNS = 2048,
    parameter int ROWS    = 1024
)
(
    input  logic        clk,
    input  cfg_t        cfg,
    input  logic [10:0] column,
    input  logic [9:0]  row,
    input  cmd_t        cmd,
    output status_t     status,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  alpha,
    output logic [7:0]  escape_count
);

    localparam logic [12:0] COL_LAST = 13'(COLUMNS - 1);
    localparam logic [12:0] ROW_LAST = 13'(ROWS - 1);

    logic [10:0]        col_reg;
    logic [10:0]        col_next;
    logic [9:0]         row_reg;
    logic [9:0]         row_next;
    logic signed [11:0] col_ext;
    logic signed [10:0] row_ext;
    logic signed [43:0] pcx_reg;
    logic signed [43:0] pcy_reg;
    logic signed [SAT_W-1:0] cx_wide;
    logic signed [SAT_W-1:0] cy_wide;
    logic signed [31:0] cx_next;
    logic signed [31:0] cy_next;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic signed [63:0] pxx_reg;
    logic signed [63:0] pyy_reg;
    logic signed [63:0] pxy_reg;
    logic signed [63:0] xx_sh;
    logic signed [63:0] yy_sh;
    logic signed [63:0] xy_sh;
    logic signed [SAT_W-1:0] nx_wide;
    logic signed [SAT_W-1:0] ny_wide;
    logic [63:0]        mag;
    logic [7:0]         k_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         alpha_reg;
    logic [7:0]         count_reg;

    // Positions beyond the image clamp to its last column and row.
    assign col_next = ({2'b00, column} > COL_LAST) ? COL_LAST[10:0] : column;
    assign row_next = ({3'b000, row} > ROW_LAST) ? ROW_LAST[9:0] : row;

    assign col_ext = {1'b0, col_reg};
    assign row_ext = {1'b0, row_reg};

    assign cx_wide = {{(SAT_W - 44){pcx_reg[43]}}, pcx_reg}
                   + {{(SAT_W - 32){cfg.left_x[31]}}, cfg.left_x};
    assign cy_wide = {{(SAT_W - 44){pcy_reg[43]}}, pcy_reg}
                   + {{(SAT_W - 32){cfg.top_y[31]}}, cfg.top_y};
    assign cx_next = sat32(cx_wide);
    assign cy_next = sat32(cy_wide);

    // Floor rounding of the products is an arithmetic right shift.
    assign xx_sh = pxx_reg >>> FRAC_BITS;
    assign yy_sh = pyy_reg >>> FRAC_BITS;
    assign xy_sh = pxy_reg >>> (FRAC_BITS - 1);

    // Shifted magnitudes stay below 2^40, so 48 bits hold the sums exactly.
    assign nx_wide = xx_sh[SAT_W-1:0] - yy_sh[SAT_W-1:0]
                   + {{(SAT_W - 32){cx_reg[31]}}, cx_reg};
    assign ny_wide = xy_sh[SAT_W-1:0] + {{(SAT_W - 32){cy_reg[31]}}, cy_reg};

    // Both squares are non-negative and at most 2^62, so the sum cannot wrap.
    assign mag = pxx_reg + pyy_reg;

    assign status.on_axis  = (cx_next == 32'sd0) || (cy_next == 32'sd0);
    assign status.escape   = (mag > ESC_LIMIT);
    assign status.at_limit = (k_reg >= cfg.max_iterations);

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
        if (cmd.calc_c)
        begin
            pcx_reg <= col_ext * cfg.step_x;
            pcy_reg <= row_ext * cfg.step_y;
        end
        if (cmd.load_c)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            x_reg  <= cx_next;
            y_reg  <= cy_next;
            k_reg  <= 8'd0;
        end
        if (cmd.mul)
        begin
            pxx_reg <= x_reg * x_reg;
            pyy_reg <= y_reg * y_reg;
            pxy_reg <= x_reg * y_reg;
        end
        if (cmd.step)
        begin
            x_reg <= sat32(nx_wide);
            y_reg <= sat32(ny_wide);
            if (!cmd.first)
            begin
                k_reg <= k_reg + 8'd1;
            end
        end
        if (cmd.load_out)
        begin
            if (cmd.out_axis)
            begin
                red_reg   <= 8'd0;
                green_reg <= 8'd0;
                alpha_reg <= FULL_BYTE;
                count_reg <= 8'd0;
            end
            else if (status.escape)
            begin
                red_reg   <= 8'd0;
                green_reg <= k_reg * GREEN_STEP;
                alpha_reg <= (k_reg == 8'd0) ? 8'd0 : FULL_BYTE;
                count_reg <= k_reg;
            end
            else
            begin
                red_reg   <= FULL_BYTE;
                green_reg <= 8'd0;
                alpha_reg <= FULL_BYTE;
                count_reg <= k_reg;
            end
        end
    end

    assign red          = red_reg;
    assign green        = green_reg;
    assign alpha        = alpha_reg;
    assign escape_count = count_reg;

endmodule

/* design/mandelbrot_escape_pixel_unit.sv */
// Mandelbrot escape-time pixel unit. Each input word carries a pixel column and row; the
// unit maps it to c = (left_x + column*step_x, top_y + row*step_y) in signed Q8.24 with
// saturation, iterates z = z*z + c from z = c, and returns one output word of red, green,
// alpha and escape_count. A pixel with a zero coordinate comes back black with count zero;
// escape at iteration k > 0 gives green k*10 modulo 256; escape at iteration zero gives a
// transparent pixel; no escape up to max_iterations gives red. The unit works on one pixel
// at a time: in_stall is high from the cycle after acceptance until the result has been
// written to the output register, which then waits for out_stall to drop while the next
// word is already taken. Each iteration takes two steps: S_MUL forms the three 32 by 32
// products x*x, y*y and x*y into registers, and S_STEP adds, saturates and tests for
// escape. Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while no pixel is in flight, which the block itself
// does not enforce. Indexes beyond the list are ignored.
module mandelbrot_escape_pixel_unit
    import mep_pkg::*;
#(
    parameter int COLUMNS = 2048,
    parameter int ROWS    = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [10:0] column,
    input  logic [9:0]  row,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  alpha,
    output logic [7:0]  escape_count
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cmd_t    cmd;
    status_t status;

    // Register file decode: each index updates one field of the configuration.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_X:   cfg_next.left_x         = cfg_data;
                REG_TOP_Y:    cfg_next.top_y          = cfg_data;
                REG_STEP_X:   cfg_next.step_x         = cfg_data;
                REG_STEP_Y:   cfg_next.step_y         = cfg_data;
                REG_MAX_ITER: cfg_next.max_iterations = cfg_data[7:0];
                default:      cfg_next                = cfg_reg;
            endcase
        end
    end

    // Reset values give a view of -6.0 .. about 14.5 across and 3.5 downward in steps of 0.01.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_x         <= -32'sd100663296;
            cfg_reg.top_y          <= 32'sd58720256;
            cfg_reg.step_x         <= 32'sd167772;
            cfg_reg.step_y         <= -32'sd167772;
            cfg_reg.max_iterations <= 8'd40;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mep_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk          (clk),
        .cfg          (cfg_reg),
        .column       (column),
        .row          (row),
        .cmd          (cmd),
        .status       (status),
        .red          (red),
        .green        (green),
        .alpha        (alpha),
        .escape_count (escape_count)
    );

endmodule

/* design/mep_checker.sv */
module mep_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] alpha,
    input logic [7:0] escape_count
);

    // One pixel at a time: an accepted word closes the input side next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a pixel is already in flight");

    // A waiting output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(red) && $stable(green)
                                      && $stable(alpha) && $stable(escape_count)))
    else $error("output word changed while stalled");

    // A transparent pixel only comes from escape at iteration zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alpha == 8'd0) |-> (red == 8'd0 && green == 8'd0
                                          && escape_count == 8'd0))
    else $error("transparent pixel with colour or non-zero count");

    // A red pixel is opaque and carries no green.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && red != 8'd0) |-> (red == 8'hFF && green == 8'd0 && alpha == 8'hFF))
    else $error("malformed red pixel");

endmodule

bind mandelbrot_escape_pixel_unit mep_checker u_mep_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .red          (red),
    .green        (green),
    .alpha        (alpha),
    .escape_count (escape_count)
);
